FILE: design/sect_pkg.sv
// ----------------------------------------------------------------------------
// sect_pkg
// Shared types and status codes for the slot event compacting table.
// ----------------------------------------------------------------------------
package sect_pkg;

  localparam int unsigned SlotW    = 31;
  localparam int unsigned PayloadW = 32;
  localparam int unsigned StatusW  = 3;

  localparam logic [StatusW-1:0] ST_ACCEPTED = 3'd0;
  localparam logic [StatusW-1:0] ST_FULL     = 3'd1;
  localparam logic [StatusW-1:0] ST_REJECTED = 3'd2;
  localparam logic [StatusW-1:0] ST_NO_MATCH = 3'd3;
  localparam logic [StatusW-1:0] ST_MATCHED  = 3'd4;

  localparam logic OP_SCHEDULE = 1'b0;
  localparam logic OP_CONSUME  = 1'b1;

  typedef struct packed {
    logic                valid;
    logic                pending;
    logic [SlotW-1:0]    slot;
    logic [PayloadW-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic ins_en;
    logic start;
  } ctrl_t;

endpackage

FILE: design/sect_cell.sv
// ----------------------------------------------------------------------------
// sect_cell
// One table cell: holds an entry, takes its right neighbor's entry on a
// shift, and captures the inserted entry when it is the first free cell.
// ----------------------------------------------------------------------------
module sect_cell
  import sect_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  ctrl_t  ctrl_i,
  input  entry_t right_i,
  input  logic   left_vnext_i,
  input  entry_t ins_i,
  output logic   vnext_o,
  output entry_t entry_o
);

  logic                valid_q;
  logic                pending_q;
  logic [SlotW-1:0]    slot_q;
  logic [PayloadW-1:0] payload_q;
  entry_t              entry_q;
  entry_t              shifted;
  entry_t              entry_d;
  logic                insert;

  assign entry_q = {valid_q, pending_q, slot_q, payload_q};

  always_comb begin
    shifted = ctrl_i.shift ? right_i : entry_q;
    insert  = ctrl_i.ins_en && !shifted.valid && left_vnext_i;
    entry_d = shifted;
    if (insert) begin
      entry_d         = ins_i;
      entry_d.valid   = 1'b1;
      entry_d.pending = 1'b0;
    end
    if (ctrl_i.start) begin
      entry_d.pending = shifted.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      pending_q <= 1'b0;
    end else begin
      valid_q   <= entry_d.valid;
      pending_q <= entry_d.pending;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q    <= entry_d.slot;
    payload_q <= entry_d.payload;
  end

  assign vnext_o = shifted.valid;
  assign entry_o = entry_q;

endmodule

FILE: design/slot_event_compacting_table.sv
// A schedule transfer's result is registered and shown in the cycle after it.
// A consume transfer scans the entries that are live at its start in order:
// the head cell is examined once per cycle as the cell row shifts left.
// One schedule per cycle unless the output stalls; consumes block new input.
// Reset clears all cell valid bits, the control state and the output stage.
// ----------------------------------------------------------------------------
// slot_event_compacting_table
// Ordered event table built as a row of cells; consume drops older entries,
// removes the first match and recompacts by rotating survivors to the tail.
// ----------------------------------------------------------------------------
module slot_event_compacting_table
  import sect_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                operation_i,
  input  logic signed [31:0]  slot_number_i,
  input  logic                entry_valid_i,
  input  logic [PayloadW-1:0] event_payload_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [StatusW-1:0]  status_o,
  output logic [SlotW-1:0]    matched_slot_o,
  output logic [PayloadW-1:0] matched_payload_o
);

  typedef enum logic {StIdle, StRun} state_e;

  state_e               state_q;
  logic                 out_valid_q;
  logic [StatusW-1:0]   status_q;
  logic [SlotW-1:0]     mslot_q;
  logic [PayloadW-1:0]  mpay_q;
  logic [SlotW-1:0]     target_q;
  logic                 found_q;

  entry_t               cell_entry [TABLE_DEPTH];
  entry_t               cell_right [TABLE_DEPTH];
  logic   [TABLE_DEPTH-1:0] vnext;
  ctrl_t                ctrl;
  entry_t               ins;
  entry_t               head;

  logic out_free;
  logic accept;
  logic negative;
  logic sched_ok;
  logic full;
  logic head_older;
  logic head_match;
  logic run_done;
  logic out_set;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign negative   = slot_number_i[31];
  assign full       = cell_entry[TABLE_DEPTH-1].valid;
  assign sched_ok   = entry_valid_i && !negative && !full;
  assign head       = cell_entry[0];
  assign head_older = head.slot < target_q;
  assign head_match = !found_q && (head.slot == target_q);
  assign run_done   = !head.pending;
  assign out_set    = (state_q == StIdle) ?
                      (accept && ((operation_i == OP_SCHEDULE) || negative)) :
                      (run_done && out_free);

  always_comb begin
    ctrl.start  = accept && (operation_i == OP_CONSUME) && !negative;
    ctrl.shift  = (state_q == StRun) && head.pending;
    ctrl.ins_en = 1'b0;
    ins         = head;
    if (state_q == StIdle) begin
      ctrl.ins_en = accept && (operation_i == OP_SCHEDULE) && sched_ok;
      ins.slot    = slot_number_i[SlotW-1:0];
      ins.payload = event_payload_i;
    end else begin
      ctrl.ins_en = head.pending && !head_older && !head_match;
    end
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign cell_right[i] = '0;
    end else begin : g_mid
      assign cell_right[i] = cell_entry[i+1];
    end

    sect_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .right_i     (cell_right[i]),
      .left_vnext_i((i == 0) ? 1'b1 : vnext[(i == 0) ? 0 : i-1]),
      .ins_i       (ins),
      .vnext_o     (vnext[i]),
      .entry_o     (cell_entry[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      status_q    <= ST_ACCEPTED;
      mslot_q     <= '0;
      mpay_q      <= '0;
      target_q    <= '0;
      found_q     <= 1'b0;
    end else begin
      out_valid_q <= out_set || (out_valid_q && !out_ready_i);
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            if (operation_i == OP_SCHEDULE) begin
              mslot_q     <= '0;
              mpay_q      <= '0;
              priority if (!entry_valid_i || negative) begin
                status_q <= ST_REJECTED;
              end else if (full) begin
                status_q <= ST_FULL;
              end else begin
                status_q <= ST_ACCEPTED;
              end
            end else if (negative) begin
              status_q    <= ST_REJECTED;
              mslot_q     <= '0;
              mpay_q      <= '0;
            end else begin
              target_q <= slot_number_i[SlotW-1:0];
              found_q  <= 1'b0;
              mslot_q  <= '0;
              mpay_q   <= '0;
              state_q  <= StRun;
            end
          end
        end
        StRun: begin
          if (run_done) begin
            if (out_free) begin
              status_q    <= found_q ? ST_MATCHED : ST_NO_MATCH;
              state_q     <= StIdle;
            end
          end else if (!head_older && head_match) begin
            found_q <= 1'b1;
            mslot_q <= head.slot;
            mpay_q  <= head.payload;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign matched_slot_o    = mslot_q;
  assign matched_payload_o = mpay_q;

endmodule
